/* hdl/rce_pkg.sv */
// shared types, constants and register indexes of the release character escaper
package rce_pkg;

	localparam int MAX_TERM_LEN_DEF = 4;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPW              = $clog2(QUEUE_DEPTH);

	localparam logic [7:0]  DATA_SEP_RST  = 8'd58;
	localparam logic [7:0]  COMP_SEP_RST  = 8'd43;
	localparam logic [7:0]  RELEASE_RST   = 8'd63;
	localparam logic [2:0]  TERM_LEN_RST  = 3'd2;
	localparam logic [31:0] TERM_BYTES_RST = 32'h0000_0A22;

	localparam logic [2:0] REG_DATA_SEP   = 3'd0;
	localparam logic [2:0] REG_COMP_SEP   = 3'd1;
	localparam logic [2:0] REG_RELEASE    = 3'd2;
	localparam logic [2:0] REG_TERM_LEN   = 3'd3;
	localparam logic [2:0] REG_TERM_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0]  data_sep;
		logic [7:0]  comp_sep;
		logic [7:0]  release_byte;
		logic [2:0]  term_len;
		logic [31:0] term_bytes;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} emit_t;

	typedef enum logic [2:0] {
		CL_IDLE,
		CL_RAW,
		CL_ESC,
		CL_MATCH,
		CL_WAIT,
		CL_PASS
	} head_class_t;

endpackage

/* hdl/rce_queue.sv */
// ingest queue between the stream input and the escape engine
module rce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rce_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output rce_pkg::item_t head_item
);
	import rce_pkg::*;

	item_t          mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (count_q == (QPW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

endmodule

/* hdl/rce_engine.sv */
// escape engine: lookahead window, terminator match and byte emission
module rce_engine #(
	parameter int MAX_TERM_LEN = rce_pkg::MAX_TERM_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rce_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  rce_pkg::item_t q_item,
	output logic           q_take,
	input  logic           slot_free,
	output rce_pkg::emit_t emit
);
	import rce_pkg::*;

	localparam int CW  = $clog2(MAX_TERM_LEN + 1);
	localparam int IW  = (MAX_TERM_LEN > 1) ? $clog2(MAX_TERM_LEN) : 1;
	localparam int TPW = ((MAX_TERM_LEN > 4) ? MAX_TERM_LEN : 4) * 8;

	logic [7:0]    win_q [MAX_TERM_LEN];
	logic [CW-1:0] fill_q;
	logic [CW-1:0] raw_q;
	logic          busy_q;
	logic          last_q;
	logic          phase_q;

	logic [CW-1:0]  eff_len;
	logic [TPW-1:0] term_pad;
	logic [7:0]     head;
	logic           special;
	logic           match;
	head_class_t    cls;
	logic           step_end;
	logic           two_byte;
	logic           go;
	logic           pop;

	assign term_pad = TPW'(cfg.term_bytes);
	assign eff_len  = (int'(cfg.term_len) > MAX_TERM_LEN) ? CW'(MAX_TERM_LEN)
		: CW'(cfg.term_len);
	assign head     = win_q[0];
	assign special  = (head == cfg.data_sep) || (head == cfg.comp_sep)
		|| (head == cfg.release_byte);

	always_comb begin
		match = 1'b1;
		for (int k = 0; k < MAX_TERM_LEN; k++) begin
			if ((k < int'(eff_len)) && (win_q[k] != term_pad[8*k +: 8])) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		if (fill_q == '0) begin
			cls = CL_IDLE;
		end else if (raw_q != '0) begin
			cls = CL_RAW;
		end else if (special) begin
			cls = CL_ESC;
		end else if ((eff_len != '0) && (fill_q >= eff_len) && match) begin
			cls = CL_MATCH;
		end else if ((eff_len != '0) && (fill_q < eff_len) && !last_q) begin
			cls = CL_WAIT;
		end else begin
			cls = CL_PASS;
		end
	end

	assign step_end = !busy_q || (cls == CL_IDLE) || (cls == CL_WAIT);
	assign q_take   = step_end && q_valid;
	assign two_byte = (cls == CL_ESC) || (cls == CL_MATCH);
	assign go       = !step_end && slot_free;
	assign pop      = go && (!two_byte || phase_q);

	// release byte first on the first phase of a two byte emission
	always_comb begin
		emit.valid = go;
		emit.data  = (two_byte && !phase_q) ? cfg.release_byte : head;
		emit.last  = last_q && (fill_q == CW'(1)) && !(two_byte && !phase_q);
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			win_q[fill_q[IW-1:0]] <= q_item.data;
		end else if (pop) begin
			for (int i = 0; i < MAX_TERM_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
		if (q_take) begin
			last_q <= q_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			raw_q   <= '0;
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (step_end) begin
				busy_q <= q_valid;
			end
			if (q_take) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop) begin
				fill_q <= fill_q - CW'(1);
			end
			if (go) begin
				phase_q <= two_byte && !phase_q;
			end
			if (pop) begin
				if (cls == CL_MATCH) begin
					raw_q <= eff_len - CW'(1);
				end else if (cls == CL_RAW) begin
					raw_q <= raw_q - CW'(1);
				end
			end
		end
	end

endmodule

/* hdl/release_char_escaper.sv */
// top level of the release character escaper
// Release character escaper: a byte stream (tlast on the final byte of a
// string) comes out with the release byte placed before every data
// separator, component separator and release byte, and once before each
// occurrence of the segment terminator string, whose remaining bytes then
// pass unchecked. Up to MAX_TERM_LEN bytes are held back in a lookahead
// window until the terminator can be decided; tlast flushes the window. The
// engine sends one output byte per cycle while the output register can take
// it, and takes no byte from the queue in a cycle in which it sends one. A
// four deep queue in front of the engine lets the input run ahead while the
// engine stalls on the output, and a single output register holds a finished
// byte while the next one is worked out. Registers are to be written through
// cfg_we/cfg_index/cfg_data with the stream quiet, which the block does not
// enforce; a change applies to bytes still held in the window as well.
module release_char_escaper #(
	parameter int MAX_TERM_LEN = rce_pkg::MAX_TERM_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
	input  logic        s_axis_tlast,   // in_last
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
	output logic        m_axis_tlast,   // out_last
	// register writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rce_pkg::*;

	cfg_t       cfg_q;
	logic       q_full;
	logic       q_valid;
	item_t      q_item;
	item_t      in_item;
	logic       q_take;
	logic       slot_free;
	emit_t      emit;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	// configuration registers, reset to the usual separator set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_sep     <= DATA_SEP_RST;
			cfg_q.comp_sep     <= COMP_SEP_RST;
			cfg_q.release_byte <= RELEASE_RST;
			cfg_q.term_len     <= TERM_LEN_RST;
			cfg_q.term_bytes   <= TERM_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DATA_SEP:   cfg_q.data_sep     <= cfg_data[7:0];
				REG_COMP_SEP:   cfg_q.comp_sep     <= cfg_data[7:0];
				REG_RELEASE:    cfg_q.release_byte <= cfg_data[7:0];
				REG_TERM_LEN:   cfg_q.term_len     <= cfg_data[2:0];
				REG_TERM_BYTES: cfg_q.term_bytes   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: accept requests into the queue
	assign s_axis_tready = !q_full;
	assign in_item.data  = s_axis_tdata;
	assign in_item.last  = s_axis_tlast;

	rce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_item (in_item),
		.full      (q_full),
		.pop       (q_take),
		.not_empty (q_valid),
		.head_item (q_item)
	);

	// back: escape engine, one output byte per cycle while the output register can take it
	rce_engine #(
		.MAX_TERM_LEN (MAX_TERM_LEN)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take),
		.slot_free (slot_free),
		.emit      (emit)
	);

	// output register, which can be refilled in the cycle it is taken
	assign slot_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_data_q <= emit.data;
			out_last_q <= emit.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* hdl/rce_checker.sv */
// port level checks of the release character escaper, bound to the top level
module rce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);
	logic [3:0] open_strings_q;
	logic       in_last_acc;
	logic       out_last_acc;

	assign in_last_acc  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_last_acc = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_strings_q <= '0;
		end else if (in_last_acc && !out_last_acc) begin
			open_strings_q <= open_strings_q + 4'd1;
		end else if (out_last_acc && !in_last_acc) begin
			open_strings_q <= open_strings_q - 4'd1;
		end
	end

	// a stalled output byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output byte changed while stalled");

	// the queue only fills on an accepted request
	a_ready_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
		else $error("input ready dropped without a request");

	// no end of string leaves before its last input byte came in
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_last_acc |-> (open_strings_q != 4'd0) || in_last_acc)
		else $error("end of string sent with none outstanding");

	// nothing is offered while held in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind release_char_escaper rce_checker u_rce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
